[rtl/pbrq_pkg.sv]
// ----------------------------------------------------------------------------
// pbrq_pkg
// Shared sizes, opcodes, interface types and helper functions for the
// priority bitmap ready queue.
// ----------------------------------------------------------------------------
`default_nettype none

package pbrq_pkg;

    // sizing
    localparam int NUM_PRIO     = 64;
    localparam int HANDLE_WIDTH = 32;
    localparam int ROW_COUNT    = (NUM_PRIO + 7) / 8;
    localparam int PRIO_AW      = $clog2(NUM_PRIO);
    localparam int ROW_BITS_W   = ROW_COUNT * 8;

    // port field widths
    localparam int OP_W     = 2;
    localparam int PRIO_W   = 6;
    localparam int HANDLE_W = 32;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // configuration register indexes (word index, byte address bit 2)
    localparam logic CFG_IDLE_PRIORITY = 1'b0;

    localparam logic [PRIO_W-1:0] IDLE_PRIO_RESET = 6'd63;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    // command from the front end to the bitmap
    typedef struct packed {
        logic              add;
        logic              remove;
        logic              clear;
        logic [PRIO_W-1:0] prio;
    } t_bitmap_cmd;

    // bitmap state seen by the lookup and output stage
    typedef struct packed {
        logic [ROW_BITS_W-1:0] rows;
        logic [7:0]            group;
        logic                  hit;
    } t_bitmap_state;

    // index of the lowest set bit of a byte, zero when the byte is empty
    function automatic logic [2:0] lowest_bit(input logic [7:0] byte_in);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (byte_in[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    // port handle to stored handle
    function automatic logic [HANDLE_WIDTH-1:0] to_store(input logic [HANDLE_W-1:0] h);
        logic [HANDLE_WIDTH-1:0] s;
        s = '0;
        for (int i = 0; i < HANDLE_WIDTH; i++) begin
            if (i < HANDLE_W) begin
                s[i] = h[i];
            end
        end
        return s;
    endfunction

    // stored handle to port handle
    function automatic logic [HANDLE_W-1:0] from_store(input logic [HANDLE_WIDTH-1:0] s);
        logic [HANDLE_W-1:0] h;
        h = '0;
        for (int i = 0; i < HANDLE_W; i++) begin
            if (i < HANDLE_WIDTH) begin
                h[i] = s[i];
            end
        end
        return h;
    endfunction

endpackage

`default_nettype wire

[rtl/pbrq_ram.sv]
// ----------------------------------------------------------------------------
// pbrq_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/pbrq_bitmap.sv]
// ----------------------------------------------------------------------------
// pbrq_bitmap
// Ready bits per priority (rows of eight) and the group byte over the rows.
// The ready bit of a priority also marks its handle slot as holding data.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_bitmap
    import pbrq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  wire t_bitmap_cmd           i_cmd,
    input  wire logic     [PRIO_W-1:0] i_idle_priority,
    output t_bitmap_state              o_state
);

    logic [NUM_PRIO-1:0] r_ready, n_ready;
    logic [7:0]          r_group, n_group;
    logic                r_hit, n_hit;

    logic               in_range;
    logic [PRIO_AW-1:0] idx;
    logic [2:0]         row;
    logic               row_busy;

    assign in_range = {1'b0, i_cmd.prio} < (PRIO_W + 1)'(NUM_PRIO);
    assign idx      = i_cmd.prio[PRIO_AW-1:0];
    assign row      = i_cmd.prio[5:3];

    // next bitmap for the accepted command
    always_comb begin
        n_ready  = r_ready;
        n_group  = r_group;
        n_hit    = 1'b0;
        row_busy = 1'b0;
        if (i_cmd_valid) begin
            if (i_cmd.clear) begin
                n_ready = '0;
                n_group = '0;
            end else if (i_cmd.add && in_range) begin
                n_ready[idx] = 1'b1;
                n_group[row] = 1'b1;
            end else if (i_cmd.remove && in_range) begin
                n_hit = r_ready[idx];
                if (i_cmd.prio != i_idle_priority) begin
                    n_ready[idx] = 1'b0;
                    // row still holding any ready priority
                    for (int i = 0; i < NUM_PRIO; i++) begin
                        if ((i >> 3) == int'(row)) begin
                            row_busy = row_busy | n_ready[i];
                        end
                    end
                    if (!row_busy) begin
                        n_group[row] = 1'b0;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= '0;
            r_group <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_ready <= n_ready;
            r_group <= n_group;
            r_hit   <= n_hit;
        end
    end

    // bitmap state out, ready bits padded out to whole rows
    always_comb begin
        o_state                    = '0;
        o_state.rows[NUM_PRIO-1:0] = r_ready;
        o_state.group              = r_group;
        o_state.hit                = r_hit;
    end

endmodule

`default_nettype wire

[rtl/pbrq_lookup.sv]
// ----------------------------------------------------------------------------
// pbrq_lookup
// Highest ready priority: lowest set bit of the group byte, then of that row.
// ----------------------------------------------------------------------------
`default_nettype none

module pbrq_lookup
    import pbrq_pkg::*;
(
    input  wire t_bitmap_state              i_state,
    output logic               [PRIO_W-1:0] o_highest_priority,
    output logic                            o_none_ready
);

    logic [63:0] all_rows;
    logic [2:0]  row;
    logic [2:0]  bit_idx;
    logic [7:0]  row_byte;

    // widen to eight rows so any row index is in range
    always_comb begin
        all_rows = '0;
        for (int i = 0; i < ROW_BITS_W; i++) begin
            all_rows[i] = i_state.rows[i];
        end
    end

    // two-level lowest-bit search
    assign row      = lowest_bit(i_state.group);
    assign row_byte = all_rows[{row, 3'b000} +: 8];
    assign bit_idx  = lowest_bit(row_byte);

    assign o_none_ready       = (i_state.group == 8'd0);
    assign o_highest_priority = o_none_ready ? '0 : {row, bit_idx};

endmodule

`default_nettype wire

[rtl/priority_bitmap_ready_queue_top.sv]
// ----------------------------------------------------------------------------
// priority_bitmap_ready_queue_top
// Ready queue of 64 priorities with one task handle each, two-level bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   A command (i_opcode, i_priority_req, i_task_handle) is taken at a clock
//   edge with start high and busy low. busy stays low, so a command can be
//   issued on every cycle.
//   Opcodes: add stores a handle and marks its priority ready, remove returns
//   the handle and unmarks it (the idle priority is returned but kept),
//   query only reports, clear empties the queue.
//   Each command gives one result in the next cycle: o_result_valid is high for
//   that single cycle with o_removed_handle, o_highest_priority and
//   o_none_ready. Throughput is 1 item per cycle; the removed handle comes
//   from the registered read of the handle RAM.
//   The receiver cannot stall; results must be taken when strobed.
//   Reset clears all ready bits and the group byte at once and sets the idle
//   priority to 63; handle slots not marked ready read as zero.
//   The APB port holds the idle priority at byte address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_bitmap_ready_queue_top
    import pbrq_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // command channel
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OP_W-1:0]     i_opcode,
    input  wire logic [PRIO_W-1:0]   i_priority_req,
    input  wire logic [HANDLE_W-1:0] i_task_handle,
    // result channel
    output logic                     o_result_valid,
    output logic      [HANDLE_W-1:0] o_removed_handle,
    output logic      [PRIO_W-1:0]   o_highest_priority,
    output logic                     o_none_ready,
    // configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    logic [PRIO_W-1:0]       r_idle_priority;
    logic                    r_result_valid;
    logic                    accept;
    logic                    cfg_write;
    logic                    in_range;
    t_opcode                 op;
    t_bitmap_cmd             cmd;
    t_bitmap_state           bm_state;
    logic [HANDLE_WIDTH-1:0] ram_rdata;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;
    assign op     = t_opcode'(i_opcode);

    assign in_range = {1'b0, i_priority_req} < (PRIO_W + 1)'(NUM_PRIO);

    // configuration register
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == CFG_IDLE_PRIORITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_priority <= IDLE_PRIO_RESET;
        end else if (cfg_write) begin
            r_idle_priority <= pwdata[PRIO_W-1:0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDLE_PRIORITY)
                    ? {{(PDATA_W - PRIO_W){1'b0}}, r_idle_priority} : '0;

    // decode the command
    always_comb begin
        cmd.add    = (op == OP_ADD);
        cmd.remove = (op == OP_REMOVE);
        cmd.clear  = (op == OP_CLEAR);
        cmd.prio   = i_priority_req;
    end

    // handle store
    pbrq_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (NUM_PRIO)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_en    (accept),
        .i_we    (accept && (op == OP_ADD) && in_range),
        .i_addr  (i_priority_req[PRIO_AW-1:0]),
        .i_wdata (to_store(i_task_handle)),
        .o_rdata (ram_rdata)
    );

    // ready bits and group byte
    pbrq_bitmap u_bitmap (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (accept),
        .i_cmd           (cmd),
        .i_idle_priority (r_idle_priority),
        .o_state         (bm_state)
    );

    // highest ready priority from the updated bitmap
    pbrq_lookup u_lookup (
        .i_state            (bm_state),
        .o_highest_priority (o_highest_priority),
        .o_none_ready       (o_none_ready)
    );

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= accept;
        end
    end

    assign o_result_valid   = r_result_valid;
    assign o_removed_handle = bm_state.hit ? from_store(ram_rdata) : '0;

endmodule

`default_nettype wire
